@@ rtl/clf_pkg.sv @@
`default_nettype none

package clf_pkg;

    localparam int MAX_VALUE_LEN = 32;
    localparam int CMD_CHARS     = 4;
    localparam int CCOUNT_W      = $clog2(CMD_CHARS + 1);
    localparam int CIDX_W        = $clog2(CMD_CHARS);
    localparam int VCNT_MIN_W    = $clog2(MAX_VALUE_LEN + 1);
    localparam int VCNT_W        = (VCNT_MIN_W > 6) ? VCNT_MIN_W : 6;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NON_LETTER = 3'd1;
    localparam logic [2:0] ERR_AFTER_DONE = 3'd2;
    localparam logic [2:0] ERR_CR_NO_LF   = 3'd3;
    localparam logic [2:0] ERR_JUNK       = 3'd4;
    localparam logic [2:0] ERR_NUL        = 3'd5;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd6;

    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_Z   = 8'h5A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } clf_in_t;

    typedef struct packed {
        logic [2:0]  error_code;
        logic        message_done;
        logic [31:0] command_word;
        logic [7:0]  value_byte;
        logic        value_valid;
        logic [4:0]  value_index;
        logic [5:0]  value_length;
        logic        has_value;
        logic        ends_with_crlf;
    } clf_out_t;

endpackage

`default_nettype wire

@@ rtl/clf_core.sv @@
`default_nettype none

module clf_core
    import clf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire clf_in_t  item,
    output clf_out_t      result
);

    logic [7:0]          chars_reg [CMD_CHARS];
    logic [CCOUNT_W-1:0] ccount_reg, ccount_next;
    logic [VCNT_W-1:0]   vcount_reg, vcount_next;
    logic                started_reg, started_next;
    logic                await_reg, await_next;
    logic                complete_reg, complete_next;
    logic                crlf_reg, crlf_next;
    logic [2:0]          error_reg, error_next;
    logic                chars_we;
    logic                stored;
    logic [7:0]          c;
    logic                is_ws;
    logic [2:0]          err;

    assign c     = item.data_byte;
    assign is_ws = (c == CH_SP) || (c == CH_TAB);

    always_comb
    begin
        ccount_next   = ccount_reg;
        vcount_next   = vcount_reg;
        started_next  = started_reg;
        await_next    = await_reg;
        complete_next = complete_reg;
        crlf_next     = crlf_reg;
        error_next    = error_reg;
        chars_we      = 1'b0;
        stored        = 1'b0;
        err           = ERR_NONE;
        if (en)
        begin
            if (item.func == FUNC_RELEASE)
            begin
                ccount_next   = '0;
                vcount_next   = '0;
                started_next  = 1'b0;
                await_next    = 1'b0;
                complete_next = 1'b0;
                error_next    = ERR_NONE;
            end
            else if (error_reg == ERR_NONE)
            begin
                if (ccount_reg < CCOUNT_W'(CMD_CHARS))
                begin
                    if (c < CH_A || c > CH_Z)
                        err = ERR_NON_LETTER;
                    else
                    begin
                        chars_we    = 1'b1;
                        ccount_next = ccount_reg + 1'b1;
                    end
                end
                else if (complete_reg)
                    err = ERR_AFTER_DONE;
                else if (await_reg)
                begin
                    if (c != CH_LF)
                        err = ERR_CR_NO_LF;
                    else
                    begin
                        await_next    = 1'b0;
                        crlf_next     = 1'b1;
                        complete_next = 1'b1;
                    end
                end
                else if (vcount_reg == '0 && is_ws)
                    started_next = 1'b1;
                else if (vcount_reg == '0 && !started_reg && c != CH_CR && c != CH_LF)
                    err = ERR_JUNK;
                else if (c == CH_CR)
                    await_next = 1'b1;
                else if (c == CH_LF)
                begin
                    crlf_next     = 1'b0;
                    complete_next = 1'b1;
                end
                else if (c == CH_NUL)
                    err = ERR_NUL;
                else if (vcount_reg >= VCNT_W'(MAX_VALUE_LEN))
                    err = ERR_TOO_LONG;
                else
                begin
                    stored      = 1'b1;
                    vcount_next = vcount_reg + 1'b1;
                end
                error_next = err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccount_reg   <= '0;
            vcount_reg   <= '0;
            started_reg  <= 1'b0;
            await_reg    <= 1'b0;
            complete_reg <= 1'b0;
            crlf_reg     <= 1'b0;
            error_reg    <= ERR_NONE;
        end
        else
        begin
            ccount_reg   <= ccount_next;
            vcount_reg   <= vcount_next;
            started_reg  <= started_next;
            await_reg    <= await_next;
            complete_reg <= complete_next;
            crlf_reg     <= crlf_next;
            error_reg    <= error_next;
        end
    end

    // command letters carry no reset
    always_ff @(posedge clk)
    begin
        if (chars_we)
            chars_reg[ccount_reg[CIDX_W-1:0]] <= c;
    end

    always_comb
    begin
        result.error_code     = error_next;
        result.message_done   = complete_next;
        result.command_word   = '0;
        if (complete_next)
            result.command_word = {chars_reg[0], chars_reg[1], chars_reg[2], chars_reg[3]};
        result.value_byte     = stored ? c : 8'h00;
        result.value_valid    = stored;
        result.value_index    = stored ? vcount_reg[4:0] : 5'd0;
        result.value_length   = vcount_next[5:0];
        result.has_value      = started_next;
        result.ends_with_crlf = crlf_next;
    end

    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (en && item.func == FUNC_BYTE && error_reg != ERR_NONE)
            |=> (error_reg == $past(error_reg)))
        else $error("sticky error changed without release");

    a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VCNT_W'(MAX_VALUE_LEN))
        else $error("value count past limit");

    a_complete_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        complete_reg |-> (ccount_reg == CCOUNT_W'(CMD_CHARS)))
        else $error("line complete without full command");

    a_await_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(await_reg && complete_reg))
        else $error("awaiting lf on a complete line");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (en && item.func == FUNC_RELEASE)
            |=> (ccount_reg == '0 && error_reg == ERR_NONE && !complete_reg
                 && crlf_reg == $past(crlf_reg)))
        else $error("release did not clear parse state");

endmodule

`default_nettype wire

@@ rtl/command_line_framer_top.sv @@
// an accepted item waits in the input register; its result goes to the result register
// throughput: one item per cycle while the receiver keeps out_ready high, set by the
// single parse step between the input register and the result register
// reset: rst_n clears all parse state but the command letters, and both valid flags;
// the ending flag reads as LF after reset
`default_nettype none

module command_line_framer_top
    import clf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire clf_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output clf_out_t      out_data
);

    logic     in_valid_reg, in_valid_next;
    clf_in_t  in_item_reg;
    logic     out_valid_reg, out_valid_next;
    clf_out_t out_data_reg;
    clf_out_t core_result;
    logic     advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign in_valid_next  = (in_valid && in_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    clf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
        if (advance)
            out_data_reg <= core_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ sim/command_line_framer_top_tb.sv @@
`default_nettype none

module command_line_framer_top_tb
    import clf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;

    localparam clf_out_t CLEAR_RESULT = '0;
    localparam clf_out_t NON_LETTER_RESULT =
        '{ERR_NON_LETTER, 1'b0, 32'd0, 8'd0, 1'b0, 5'd0, 6'd0, 1'b0, 1'b0};

    typedef struct packed {
        clf_in_t  item;
        logic     typed;
        clf_out_t result;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    clf_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    clf_out_t out_data;

    // expected results of accepted items, oldest first
    clf_out_t pending_results [$];
    clf_in_t  line_q [$];

    int fails = 0;
    int framed_cnt = 0;
    int cycle_cnt = 0;
    int tx_idle_pct = 12;
    int rx_idle_pct = 86;
    logic hold_off = 1'b0;

    // framer state as seen by the checker
    logic [7:0] cmd_chars [CMD_CHARS];
    logic [2:0] cmd_count = '0;
    logic [5:0] val_count = '0;
    logic       val_started = 1'b0;
    logic       await_lf = 1'b0;
    logic       line_done = 1'b0;
    logic       crlf = 1'b0;
    logic [2:0] sticky = ERR_NONE;

    stim_row_t opening_rows [28] = '{
        '{'{FUNC_RELEASE, 8'hFF}, 1'b1, CLEAR_RESULT},
        '{'{FUNC_BYTE, 8'h40}, 1'b1, NON_LETTER_RESULT},
        '{'{FUNC_BYTE, CH_A}, 1'b1, NON_LETTER_RESULT},
        '{'{FUNC_RELEASE, 8'h00}, 1'b1, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_A}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_Z}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_Z}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_A}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_TAB}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_SP}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, 8'hFF}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, 8'h01}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_NUL}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_RELEASE, 8'h00}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_Z}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_A}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_Z}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_A}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_LF}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, 8'h5B}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_RELEASE, 8'h00}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, 8'h51}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, 8'h55}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, 8'h49}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, 8'h54}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_CR}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_BYTE, CH_LF}, 1'b0, CLEAR_RESULT},
        '{'{FUNC_RELEASE, 8'h00}, 1'b0, CLEAR_RESULT}
    };

    command_line_framer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one character through the line parser, returns the error it raises
    function automatic logic [2:0] parse_char(input logic [7:0] c, output logic stored,
                                              output logic [4:0] at);
        stored = 1'b0;
        at = '0;
        if (cmd_count < CMD_CHARS)
        begin
            if (c < CH_A || c > CH_Z)
                return ERR_NON_LETTER;
            cmd_chars[cmd_count[1:0]] = c;
            cmd_count++;
            return ERR_NONE;
        end
        if (line_done)
            return ERR_AFTER_DONE;
        if (await_lf)
        begin
            if (c != CH_LF)
                return ERR_CR_NO_LF;
            await_lf = 1'b0;
            crlf = 1'b1;
            line_done = 1'b1;
            return ERR_NONE;
        end
        // whitespace before the first value character is separator
        if (val_count == 0)
        begin
            if (c == CH_SP || c == CH_TAB)
            begin
                val_started = 1'b1;
                return ERR_NONE;
            end
            if (!val_started && c != CH_CR && c != CH_LF)
                return ERR_JUNK;
        end
        if (c == CH_CR)
        begin
            await_lf = 1'b1;
            return ERR_NONE;
        end
        if (c == CH_LF)
        begin
            crlf = 1'b0;
            line_done = 1'b1;
            return ERR_NONE;
        end
        if (c == CH_NUL)
            return ERR_NUL;
        if (val_count >= MAX_VALUE_LEN)
            return ERR_TOO_LONG;
        stored = 1'b1;
        at = val_count[4:0];
        val_count++;
        return ERR_NONE;
    endfunction

    function automatic clf_out_t frame_byte(input clf_in_t it);
        clf_out_t   r;
        logic       stored;
        logic [4:0] at;
        r = '0;
        stored = 1'b0;
        at = '0;
        if (it.func == FUNC_RELEASE)
        begin
            // ending flag survives a release
            cmd_count = '0;
            val_count = '0;
            val_started = 1'b0;
            await_lf = 1'b0;
            line_done = 1'b0;
            sticky = ERR_NONE;
        end
        else if (sticky == ERR_NONE)
            sticky = parse_char(it.data_byte, stored, at);
        r.error_code = sticky;
        r.message_done = line_done;
        if (line_done)
            r.command_word = {cmd_chars[0], cmd_chars[1], cmd_chars[2], cmd_chars[3]};
        if (stored)
            r.value_byte = it.data_byte;
        r.value_valid = stored;
        r.value_index = at;
        r.value_length = val_count;
        r.has_value = val_started;
        r.ends_with_crlf = crlf;
        return r;
    endfunction

    task automatic offer(input clf_in_t it, input logic typed, input clf_out_t typed_result);
        clf_out_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        framed_cnt++;
        predicted = frame_byte(it);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    function automatic logic [7:0] value_char();
        logic [7:0] b;
        b = 8'($urandom_range(255, 1));
        if (b == CH_CR || b == CH_LF)
            b = 8'h7E;
        return b;
    endfunction

    // one command line, mostly well formed, sometimes broken or plain noise
    task automatic build_line();
        int n;
        int seps;
        int vlen;
        int pick;
        int pos;
        line_q.delete();
        if ($urandom_range(99) < 8)
        begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
                line_q.push_back('{($urandom_range(4) == 0) ? FUNC_RELEASE : FUNC_BYTE,
                                   8'($urandom)});
            return;
        end
        for (int i = 0; i < CMD_CHARS; i++)
            line_q.push_back('{FUNC_BYTE, CH_A + 8'($urandom_range(25))});
        if ($urandom_range(99) < 70)
        begin
            seps = $urandom_range(3, 1);
            for (int i = 0; i < seps; i++)
                line_q.push_back('{FUNC_BYTE, ($urandom_range(1) == 0) ? CH_SP : CH_TAB});
            pick = $urandom_range(99);
            if (pick < 75)
                vlen = $urandom_range(12);
            else if (pick < 95)
                vlen = $urandom_range(31, 13);
            else
                vlen = $urandom_range(36, 30);
            for (int i = 0; i < vlen; i++)
                line_q.push_back('{FUNC_BYTE, value_char()});
            if (vlen > 0 && $urandom_range(99) < 4)
                line_q[line_q.size() - 1 - $urandom_range(vlen - 1)].data_byte = CH_NUL;
        end
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            line_q.push_back('{FUNC_BYTE, CH_CR});
            line_q.push_back('{FUNC_BYTE, 8'($urandom)});
        end
        else
        begin
            if (pick < 56)
                line_q.push_back('{FUNC_BYTE, CH_CR});
            line_q.push_back('{FUNC_BYTE, CH_LF});
        end
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            pos = $urandom_range(line_q.size() - 1);
            line_q[pos].data_byte = 8'($urandom);
        end
        else if (pick < 10)
            line_q.insert(CMD_CHARS, '{FUNC_BYTE, 8'($urandom)});
        if ($urandom_range(99) < 8)
            line_q.push_back('{FUNC_BYTE, 8'($urandom)});
        if ($urandom_range(99) < 93)
            line_q.push_back('{FUNC_RELEASE, 8'($urandom)});
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        clf_out_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: %h", out_data);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("error_code", 32'(want.error_code),
                            32'(out_data.error_code));
                check_field("message_done", 32'(want.message_done),
                            32'(out_data.message_done));
                check_field("command_word", want.command_word, out_data.command_word);
                check_field("value_byte", 32'(want.value_byte),
                            32'(out_data.value_byte));
                check_field("value_valid", 32'(want.value_valid),
                            32'(out_data.value_valid));
                check_field("value_index", 32'(want.value_index),
                            32'(out_data.value_index));
                check_field("value_length", 32'(want.value_length),
                            32'(out_data.value_length));
                check_field("has_value", 32'(want.has_value),
                            32'(out_data.has_value));
                check_field("ends_with_crlf", 32'(want.ends_with_crlf),
                            32'(out_data.ends_with_crlf));
            end
        end
        out_ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-offs so the block backs up and drops in_ready
    initial
    begin
        for (int k = 0; k < 2; k++)
        begin
            wait (framed_cnt >= 300 + k * 1000);
            @(posedge clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("command_line_framer_top regression: fail");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (opening_rows[i])
            offer(opening_rows[i].item, opening_rows[i].typed, opening_rows[i].result);
        while (framed_cnt < RANDOM_ITEMS)
        begin
            if (framed_cnt < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 12;
                rx_idle_pct <= 86;
            end
            else if (framed_cnt < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 86;
                rx_idle_pct <= 12;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            build_line();
            while (line_q.size() != 0)
                offer(line_q.pop_front(), 1'b0, CLEAR_RESULT);
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("command_line_framer_top regression: pass");
        else
            $display("command_line_framer_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ command_line_framer_top.f @@
rtl/clf_pkg.sv
rtl/clf_core.sv
rtl/command_line_framer_top.sv
sim/command_line_framer_top_tb.sv
